// ===== rtl/core/hlga_pkg.sv =====
// shared constants, register indexes and lfsr helpers for the hex lattice gas step
package hlga_pkg;

    localparam int DIRECTIONS    = 6;
    localparam int DEF_GRID_COLS = 64;
    localparam int DEF_GRID_ROWS = 64;

    localparam int THR_W      = 17;
    localparam int BAND_W     = 6;
    localparam int LFSR_W     = 16;
    localparam int COUNT_W    = 7;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 16;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 17;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;
    localparam logic [LFSR_W-1:0]  LFSR_TAPS = 16'hB400;

    localparam logic [THR_W-1:0]  THR_RESET        = 17'd62830;
    localparam logic [BAND_W-1:0] BAND_LOW_RESET   = 6'd40;
    localparam logic [BAND_W-1:0] BAND_WIDTH_RESET = 6'd1;
    localparam logic [LFSR_W-1:0] SEED_RESET       = 16'd44257;

    localparam logic [CFG_INDEX_W-1:0] REG_SURVIVE_THRESHOLD = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BAND_LOW          = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BAND_WIDTH        = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_RANDOM_SEED       = 4'd3;

    // one galois shift, taps x^16+x^14+x^13+x^11
    function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] v);
        logic [LFSR_W-1:0] r;
        begin
            r = v >> 1;
            if (v[0])
            begin
                r = r ^ LFSR_TAPS;
            end
            return r;
        end
    endfunction

    // a zero seed would lock the lfsr
    function automatic logic [LFSR_W-1:0] seed_load(input logic [LFSR_W-1:0] v);
        begin
            return (v == '0) ? LFSR_W'(1) : v;
        end
    endfunction

endpackage

// ===== rtl/core/hex_lattice_gas_absorption_step.sv =====
// hex lattice gas step: sweeps the grid once per input word through banked direction planes
// each step reads one cell per cycle from the plane memories during the sweep; the result
// register frees the input side while the result waits on the output
// reset: registers load their defaults, lfsr loads the seed, the grid reads empty
// until the first step has written the other bank
module hex_lattice_gas_absorption_step #(
    parameter int GRID_COLS = hlga_pkg::DEF_GRID_COLS,
    parameter int GRID_ROWS = hlga_pkg::DEF_GRID_ROWS
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [hlga_pkg::IN_DATA_W-1:0]         s_axis_tdata,   // [0] inject_enable
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [hlga_pkg::OUT_DATA_W-1:0]        m_axis_tdata,   // [6:0] near_count, [13:7] far_count
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [hlga_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [hlga_pkg::CFG_DATA_W-1:0]        cfg_data
);

    localparam int TOTAL  = GRID_COLS * GRID_ROWS;
    localparam int ADDR_W = $clog2(TOTAL);
    localparam int ROW_W  = $clog2(GRID_ROWS);
    localparam int CMP_W  = (ROW_W > hlga_pkg::BAND_W + 1) ? ROW_W : hlga_pkg::BAND_W + 1;
    localparam int NDIR   = hlga_pkg::DIRECTIONS;

    localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(GRID_ROWS - 1);
    localparam logic [ROW_W-1:0]  ROW_INJECT = ROW_W'(GRID_ROWS - 2);
    localparam logic [ROW_W-1:0]  ROW_NEAR   = ROW_W'(GRID_ROWS - 4);
    localparam logic [ROW_W-1:0]  ROW_FAR    = ROW_W'(2);
    localparam logic [ADDR_W-1:0] COL_STEP   = ADDR_W'(GRID_ROWS);
    localparam logic [ADDR_W-1:0] COL_LAST   = ADDR_W'(TOTAL - GRID_ROWS);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SWEEP  = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]                           state_reg;
    logic                                 primed_reg;
    logic                                 parity_reg;
    logic                                 bank_reg;
    logic                                 inject_reg;

    logic                                 odd_reg;
    logic [ROW_W-1:0]                     y_reg;
    logic [ADDR_W-1:0]                    rd_addr_reg;
    logic [ADDR_W-1:0]                    base_reg;
    logic [ADDR_W-1:0]                    left_reg;
    logic [ADDR_W-1:0]                    right_reg;

    logic                                 s1_valid_reg;
    logic                                 s1_odd_reg;
    logic [ROW_W-1:0]                     s1_y_reg;
    logic [ADDR_W-1:0]                    s1_base_reg;
    logic [ADDR_W-1:0]                    s1_left_reg;
    logic [ADDR_W-1:0]                    s1_right_reg;

    logic [hlga_pkg::COUNT_W-1:0]         near_reg;
    logic [hlga_pkg::COUNT_W-1:0]         far_reg;
    logic [hlga_pkg::COUNT_W-1:0]         near_next;
    logic [hlga_pkg::COUNT_W-1:0]         far_next;
    logic                                 out_valid_reg;
    logic [hlga_pkg::COUNT_W-1:0]         out_near_reg;
    logic [hlga_pkg::COUNT_W-1:0]         out_far_reg;

    logic [hlga_pkg::LFSR_W-1:0]          lfsr_reg;
    logic [hlga_pkg::LFSR_W-1:0]          lfsr_next;
    logic [hlga_pkg::THR_W-1:0]           thr_reg;
    logic [hlga_pkg::BAND_W-1:0]          band_low_reg;
    logic [hlga_pkg::BAND_W-1:0]          band_width_reg;

    logic                                 in_accept;
    logic                                 col_end;
    logic                                 out_load;

    logic                                 rd_en;
    logic [ADDR_W:0]                      rd_addr;
    logic [NDIR-1:0]                      rd_data;
    logic [NDIR-1:0][ADDR_W:0]            wr_addr;
    logic [NDIR-1:0]                      wr_data;

    logic [NDIR-1:0]                      site;
    logic                                 in_band;
    logic [CMP_W-1:0]                     band_top;
    logic [ROW_W-1:0]                     y_up;
    logic [ROW_W-1:0]                     y_dn;
    logic [ROW_W-1:0]                     y_diag_up;
    logic [ROW_W-1:0]                     y_diag_dn;
    logic [ADDR_W-1:0]                    dest [0:NDIR-1];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_far_reg, out_near_reg};

    assign col_end  = (y_reg == ROW_LAST);
    assign out_load = (state_reg == ST_FINISH) && !s1_valid_reg
                      && (!out_valid_reg || m_axis_tready);

    assign rd_en   = (state_reg == ST_SWEEP);
    assign rd_addr = {bank_reg, rd_addr_reg};

    hlga_plane_mem #(
        .ADDR_W (ADDR_W)
    ) u_planes (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (s1_valid_reg),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // site value after edge masking and injection, band test, counts
    always_comb
    begin
        site = primed_reg ? rd_data : '0;
        if (s1_y_reg == '0 || s1_y_reg == ROW_LAST)
        begin
            site = '0;
        end
        if (inject_reg && s1_y_reg == ROW_INJECT && s1_odd_reg == parity_reg)
        begin
            site[0] = 1'b1;
        end

        band_top = CMP_W'(band_low_reg) + CMP_W'(band_width_reg);
        in_band  = (CMP_W'(s1_y_reg) > CMP_W'(band_low_reg))
                   && (CMP_W'(s1_y_reg) <= band_top);

        near_next = near_reg;
        far_next  = far_reg;
        if (in_accept)
        begin
            near_next = '0;
            far_next  = '0;
        end
        else if (s1_valid_reg && site[0])
        begin
            if (s1_y_reg == ROW_NEAR && near_reg != hlga_pkg::COUNT_MAX)
            begin
                near_next = near_reg + 1'b1;
            end
            if (s1_y_reg == ROW_FAR && far_reg != hlga_pkg::COUNT_MAX)
            begin
                far_next = far_reg + 1'b1;
            end
        end
    end

    // survival draws in direction order, seed write reloads the lfsr
    always_comb
    begin
        lfsr_next = lfsr_reg;
        wr_data   = site;
        for (int s = 0; s < NDIR; s++)
        begin
            if (s1_valid_reg && site[s] && in_band)
            begin
                lfsr_next  = hlga_pkg::lfsr_step(lfsr_next);
                wr_data[s] = ({1'b0, lfsr_next} < thr_reg);
            end
        end
        if (cfg_valid && cfg_ready && cfg_index == hlga_pkg::REG_RANDOM_SEED)
        begin
            lfsr_next = hlga_pkg::seed_load(cfg_data[hlga_pkg::LFSR_W-1:0]);
        end
    end

    // hex offsets, odd columns shift the diagonal targets one row down
    always_comb
    begin
        y_up      = (s1_y_reg == '0) ? ROW_LAST : s1_y_reg - 1'b1;
        y_dn      = (s1_y_reg == ROW_LAST) ? '0 : s1_y_reg + 1'b1;
        y_diag_up = s1_odd_reg ? s1_y_reg : y_up;
        y_diag_dn = s1_odd_reg ? y_dn : s1_y_reg;

        dest[0] = s1_base_reg  + ADDR_W'(y_up);
        dest[1] = s1_right_reg + ADDR_W'(y_diag_up);
        dest[2] = s1_left_reg  + ADDR_W'(y_diag_up);
        dest[3] = s1_right_reg + ADDR_W'(y_diag_dn);
        dest[4] = s1_left_reg  + ADDR_W'(y_diag_dn);
        dest[5] = s1_base_reg  + ADDR_W'(y_dn);

        for (int s = 0; s < NDIR; s++)
        begin
            wr_addr[s] = {~bank_reg, dest[s]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            primed_reg     <= 1'b0;
            parity_reg     <= 1'b0;
            bank_reg       <= 1'b0;
            inject_reg     <= 1'b0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            near_reg       <= '0;
            far_reg        <= '0;
            lfsr_reg       <= hlga_pkg::SEED_RESET;
            thr_reg        <= hlga_pkg::THR_RESET;
            band_low_reg   <= hlga_pkg::BAND_LOW_RESET;
            band_width_reg <= hlga_pkg::BAND_WIDTH_RESET;
        end
        else
        begin
            s1_valid_reg <= (state_reg == ST_SWEEP);

            lfsr_reg <= lfsr_next;
            near_reg <= near_next;
            far_reg  <= far_next;

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    hlga_pkg::REG_SURVIVE_THRESHOLD:
                    begin
                        thr_reg <= cfg_data[hlga_pkg::THR_W-1:0];
                    end
                    hlga_pkg::REG_BAND_LOW:
                    begin
                        band_low_reg <= cfg_data[hlga_pkg::BAND_W-1:0];
                    end
                    hlga_pkg::REG_BAND_WIDTH:
                    begin
                        band_width_reg <= cfg_data[hlga_pkg::BAND_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tvalid && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        inject_reg <= s_axis_tdata[0];
                        state_reg  <= ST_SWEEP;
                    end
                end
                ST_SWEEP:
                begin
                    if (col_end && base_reg == COL_LAST)
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (out_load)
                    begin
                        bank_reg      <= ~bank_reg;
                        parity_reg    <= ~parity_reg;
                        primed_reg    <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // output register load, sweep counters and stage-one payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_near_reg <= near_reg;
            out_far_reg  <= far_reg;
        end

        s1_odd_reg   <= odd_reg;
        s1_y_reg     <= y_reg;
        s1_base_reg  <= base_reg;
        s1_left_reg  <= left_reg;
        s1_right_reg <= right_reg;

        if (state_reg == ST_IDLE)
        begin
            odd_reg     <= 1'b0;
            y_reg       <= '0;
            rd_addr_reg <= '0;
            base_reg    <= '0;
            left_reg    <= COL_LAST;
            right_reg   <= COL_STEP;
        end
        else if (state_reg == ST_SWEEP)
        begin
            rd_addr_reg <= rd_addr_reg + 1'b1;
            if (col_end)
            begin
                y_reg     <= '0;
                odd_reg   <= ~odd_reg;
                left_reg  <= base_reg;
                base_reg  <= right_reg;
                right_reg <= (right_reg == COL_LAST) ? '0 : right_reg + COL_STEP;
            end
            else
            begin
                y_reg <= y_reg + 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/hlga_plane_mem.sv =====
// direction plane memories: one bit-wide memory per direction, two banks each
module hlga_plane_mem #(
    parameter int ADDR_W = 12
) (
    input  logic                                         clk,
    input  logic                                         rd_en,
    input  logic [ADDR_W:0]                              rd_addr,
    output logic [hlga_pkg::DIRECTIONS-1:0]              rd_data,
    input  logic                                         wr_en,
    input  logic [hlga_pkg::DIRECTIONS-1:0][ADDR_W:0]    wr_addr,
    input  logic [hlga_pkg::DIRECTIONS-1:0]              wr_data
);

    localparam int DEPTH = 1 << (ADDR_W + 1);

    genvar p;
    generate
        for (p = 0; p < hlga_pkg::DIRECTIONS; p++)
        begin : g_plane
            logic mem [0:DEPTH-1];

            always_ff @(posedge clk)
            begin
                if (wr_en)
                begin
                    mem[wr_addr[p]] <= wr_data[p];
                end
                if (rd_en)
                begin
                    rd_data[p] <= mem[rd_addr];
                end
            end
        end
    endgenerate

endmodule
